>>> src/ptp_pkg.sv
// Shared types, constants and a helper function for the proof table probe block.
package ptp_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int PROBE_SPAN  = 8;
    localparam int TABLE_DEPTH = (1 << INDEX_BITS) + 1 + PROBE_SPAN;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int STEP_W      = (PROBE_SPAN > 1) ? $clog2(PROBE_SPAN) : 1;

    localparam int KEY_W    = 64;
    localparam int HAND_W   = 21;
    localparam int TAG_W    = KEY_W - HAND_W;
    localparam int NUM_W    = 23;
    localparam int NODES_W  = 48;
    localparam int OFFSET_W = 8;
    localparam int PIECES   = 7;

    localparam logic [NUM_W-1:0] NUM_INF = 23'h7fffff;

    // Bit fields of the packed hand: pawn, lance, knight, silver, gold, bishop, rook.
    localparam logic [HAND_W-1:0] PIECE_FIELDS [PIECES] = '{
        21'h00001f, 21'h0000e0, 21'h000700, 21'h003800,
        21'h01c000, 21'h060000, 21'h180000
    };

    typedef enum logic [1:0] {
        HIT_MISS     = 2'd0,
        HIT_EXACT    = 2'd1,
        HIT_PROOF    = 2'd2,
        HIT_DISPROOF = 2'd3
    } hit_kind_t;

    typedef struct packed {
        logic                func;
        logic [KEY_W-1:0]    key;
        logic                side;
        logic [HAND_W-1:0]   hand;
        logic [16:0]         slot;
        logic [NUM_W-1:0]    phi_in;
        logic [NUM_W-1:0]    delta_in;
        logic [NODES_W-1:0]  nodes_in;
        logic [OFFSET_W-1:0] offset_in;
        logic                phi_loop_in;
        logic                delta_loop_in;
    } req_item_t;

    typedef struct packed {
        logic [1:0]          hit_kind;
        logic [NUM_W-1:0]    phi_out;
        logic [NUM_W-1:0]    delta_out;
        logic [NODES_W-1:0]  nodes_out;
        logic [HAND_W-1:0]   stored_hand;
        logic                phi_loop_out;
        logic                delta_loop_out;
    } rsp_item_t;

    // One table slot; a zero node count marks the slot empty.
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [HAND_W-1:0]   hand;
        logic [OFFSET_W-1:0] offset;
        logic                phi_loop;
        logic                delta_loop;
        logic [NUM_W-1:0]    phi;
        logic [NUM_W-1:0]    delta;
        logic [NODES_W-1:0]  nodes;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        entry_t            wdata;
    } table_cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [HAND_W-1:0] hand;
        logic              side;
        logic [STEP_W-1:0] step;
    } probe_ctx_t;

    typedef struct packed {
        logic      stop;
        hit_kind_t kind;
    } verdict_t;

    // True when every piece count in a is at least the count in b.
    function automatic logic covers(input logic [HAND_W-1:0] a, input logic [HAND_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < PIECES; i++)
        begin
            if ((a & PIECE_FIELDS[i]) < (b & PIECE_FIELDS[i]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

>>> src/proof_table_probe_with_hand_dominance_top.sv
// Top level of the proof table probe with hand dominance.
//
//   channel   direction  handshake              beat contents
//   req       in         req_valid / req_stall  ptp_pkg::req_item_t
//   rsp       out        rsp_valid / rsp_stall  ptp_pkg::rsp_item_t
//   cfg       in         cfg_write              or_side in cfg_data
//
// A write beat passes the states WRITE and DONE on its way to the output register; a
// probe passes READ, then EVAL for each of the k slots read (1 to PROBE_SPAN), one per
// cycle from the single port of the slot memory, then DONE. From DONE the sequencer
// returns to IDLE, where the next beat is taken. One beat is in work at a time.
// After reset a clearing pass sweeps all TABLE_DEPTH (65545) slots, one per cycle,
// and req_stall stays high for its length; configuration writes are taken throughout.
// A stalled result is held in the output register; a finished result waits in the
// sequencer until that register is free, and only then is the next beat accepted.
module proof_table_probe_with_hand_dominance_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ptp_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ptp_pkg::rsp_item_t rsp,
    input  logic               cfg_write,
    input  logic               cfg_data
);

    ptp_pkg::table_cmd_t cmd;
    ptp_pkg::entry_t     rdata;
    ptp_pkg::probe_ctx_t ctx;
    ptp_pkg::verdict_t   verdict;

    ptp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rdata     (rdata),
        .ctx       (ctx),
        .verdict   (verdict)
    );

    ptp_table u_table (
        .clk   (clk),
        .cmd   (cmd),
        .rdata (rdata)
    );

    ptp_match u_match (
        .entry   (rdata),
        .ctx     (ctx),
        .verdict (verdict)
    );

endmodule

>>> src/ptp_table.sv
// Single-ported slot memory of the table with a registered read.
module ptp_table (
    input  logic                clk,
    input  ptp_pkg::table_cmd_t cmd,
    output ptp_pkg::entry_t     rdata
);

    ptp_pkg::entry_t mem [ptp_pkg::TABLE_DEPTH];
    ptp_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        rdata_reg <= mem[cmd.addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ptp_match.sv
// Compare unit that judges one read slot against the probe.
module ptp_match (
    input  ptp_pkg::entry_t     entry,
    input  ptp_pkg::probe_ctx_t ctx,
    output ptp_pkg::verdict_t   verdict
);

    logic [ptp_pkg::OFFSET_W-1:0] step_ext;
    logic                         fwd;
    logic                         bwd;
    logic                         rel;
    logic                         is_proof;
    logic                         is_disproof;

    assign step_ext    = ptp_pkg::OFFSET_W'(ctx.step);
    assign fwd         = ptp_pkg::covers(ctx.hand, entry.hand);
    assign bwd         = ptp_pkg::covers(entry.hand, ctx.hand);
    // The dominance sense flips when the probed side is the second player.
    assign rel         = (fwd ? 1'b0 : 1'b1) ^ ctx.side;
    assign is_proof    = (entry.phi == '0) && (entry.delta == ptp_pkg::NUM_INF);
    assign is_disproof = (entry.phi == ptp_pkg::NUM_INF) && (entry.delta == '0);

    always_comb
    begin
        verdict.stop = 1'b0;
        verdict.kind = ptp_pkg::HIT_MISS;
        priority if (entry.nodes == '0)
        begin
            verdict.stop = 1'b1;
        end
        else if (entry.offset < step_ext)
        begin
            // An entry from a later home ends the cluster of this home.
            verdict.stop = 1'b1;
        end
        else if (entry.offset > step_ext || entry.tag != ctx.tag)
        begin
            verdict.stop = 1'b0;
        end
        else if (entry.hand == ctx.hand)
        begin
            verdict.stop = 1'b1;
            verdict.kind = ptp_pkg::HIT_EXACT;
        end
        else if ((fwd || bwd) && !rel && is_proof)
        begin
            verdict.stop = 1'b1;
            verdict.kind = ptp_pkg::HIT_PROOF;
        end
        else if ((fwd || bwd) && rel && is_disproof)
        begin
            verdict.stop = 1'b1;
            verdict.kind = ptp_pkg::HIT_DISPROOF;
        end
        else
        begin
            verdict.stop = 1'b0;
        end
    end

endmodule

>>> src/ptp_seq.sv
// Sequencer: clearing pass, writes, the slot scan and the result register.
module ptp_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ptp_pkg::req_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ptp_pkg::rsp_item_t   rsp,
    input  logic                 cfg_write,
    input  logic                 cfg_data,
    output ptp_pkg::table_cmd_t  cmd,
    input  ptp_pkg::entry_t      rdata,
    output ptp_pkg::probe_ctx_t  ctx,
    input  ptp_pkg::verdict_t    verdict
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_READ  = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_DONE  = 6'b100000
    } seq_state_t;

    localparam logic [ptp_pkg::ADDR_W-1:0] LAST_SLOT = ptp_pkg::ADDR_W'(ptp_pkg::TABLE_DEPTH - 1);
    localparam logic [ptp_pkg::STEP_W-1:0] LAST_STEP = ptp_pkg::STEP_W'(ptp_pkg::PROBE_SPAN - 1);

    seq_state_t                        state_reg, state_next;
    logic [ptp_pkg::ADDR_W-1:0]        clr_idx_reg, clr_idx_next;
    logic                              or_side_reg, or_side_next;
    ptp_pkg::req_item_t                item_reg, item_next;
    logic [ptp_pkg::TAG_W-1:0]         tag_reg, tag_next;
    logic [ptp_pkg::INDEX_BITS-1:0]    home_reg, home_next;
    logic [ptp_pkg::STEP_W-1:0]        step_reg, step_next;
    ptp_pkg::rsp_item_t                res_reg, res_next;
    ptp_pkg::rsp_item_t                out_reg, out_next;
    logic                              out_valid_reg, out_valid_next;

    logic                              accept;
    logic [ptp_pkg::KEY_W-1:0]         keyc;
    logic                              out_free;
    ptp_pkg::rsp_item_t                hit_item;

    assign accept   = req_valid && !req_stall;
    assign out_free = !out_valid_reg || !rsp_stall;
    // Probe key is inverted when the probed side is not the OR side.
    assign keyc     = (req.side != or_side_reg) ? ~req.key : req.key;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign ctx.tag  = tag_reg;
    assign ctx.hand = item_reg.hand;
    assign ctx.side = item_reg.side;
    assign ctx.step = step_reg;

    always_comb
    begin
        hit_item.hit_kind       = verdict.kind;
        hit_item.phi_out        = rdata.phi;
        hit_item.delta_out      = rdata.delta;
        hit_item.nodes_out      = rdata.nodes;
        hit_item.stored_hand    = rdata.hand;
        hit_item.phi_loop_out   = rdata.phi_loop;
        hit_item.delta_loop_out = rdata.delta_loop;
    end

    always_comb
    begin
        cmd.we           = 1'b0;
        cmd.addr         = ptp_pkg::ADDR_W'(home_reg);
        cmd.wdata        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.we   = 1'b1;
                cmd.addr = clr_idx_reg;
            end
            ST_WRITE:
            begin
                cmd.we               = (item_reg.slot <= LAST_SLOT);
                cmd.addr             = item_reg.slot;
                cmd.wdata.tag        = item_reg.key[ptp_pkg::KEY_W-1:ptp_pkg::HAND_W];
                cmd.wdata.hand       = item_reg.hand;
                cmd.wdata.offset     = item_reg.offset_in;
                cmd.wdata.phi_loop   = item_reg.phi_loop_in;
                cmd.wdata.delta_loop = item_reg.delta_loop_in;
                cmd.wdata.phi        = item_reg.phi_in;
                cmd.wdata.delta      = item_reg.delta_in;
                cmd.wdata.nodes      = item_reg.nodes_in;
            end
            ST_EVAL:
            begin
                // Fetch the following slot while this one is judged.
                cmd.addr = ptp_pkg::ADDR_W'(home_reg) + ptp_pkg::ADDR_W'(step_reg)
                         + ptp_pkg::ADDR_W'(1);
            end
            ST_IDLE, ST_READ, ST_DONE:
            begin
                cmd.we = 1'b0;
            end
            default:
            begin
                cmd.we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        or_side_next   = cfg_write ? cfg_data : or_side_reg;
        item_next      = item_reg;
        tag_next       = tag_reg;
        home_next      = home_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + ptp_pkg::ADDR_W'(1);
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = req;
                    tag_next  = keyc[ptp_pkg::KEY_W-1:ptp_pkg::HAND_W];
                    home_next = keyc[ptp_pkg::INDEX_BITS-1:0];
                    step_next = '0;
                    state_next = req.func ? ST_READ : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                res_next   = '0;
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (verdict.stop)
                begin
                    res_next   = (verdict.kind == ptp_pkg::HIT_MISS) ? '0 : hit_item;
                    state_next = ST_DONE;
                end
                else if (step_reg == LAST_STEP)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + ptp_pkg::STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            or_side_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            or_side_reg   <= or_side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        tag_reg  <= tag_next;
        home_reg <= home_next;
        step_reg <= step_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

>>> src/ptp_checker.sv
// Port-level checks for the proof table probe, bound to its top level.
module ptp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input ptp_pkg::rsp_item_t rsp
);

    // Only one beat is in work: an accepted request closes the input next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while the previous one was in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit_kind == ptp_pkg::HIT_MISS |->
            rsp.phi_out == '0 && rsp.delta_out == '0 && rsp.nodes_out == '0
            && rsp.stored_hand == '0 && !rsp.phi_loop_out && !rsp.delta_loop_out)
        else $error("miss result carries entry contents");

    a_proof_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit_kind == ptp_pkg::HIT_PROOF |->
            rsp.phi_out == '0 && rsp.delta_out == ptp_pkg::NUM_INF)
        else $error("superior hit without a proof value");

    a_disproof_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.hit_kind == ptp_pkg::HIT_DISPROOF |->
            rsp.phi_out == ptp_pkg::NUM_INF && rsp.delta_out == '0)
        else $error("inferior hit without a disproof value");

endmodule

bind proof_table_probe_with_hand_dominance_top ptp_checker u_ptp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
